// ----- rtl/core/fgpg_pkg.sv -----
// Shared types and constants for the frequency-group permutation generator.
`timescale 1ns / 1ps

package fgpg_pkg;

    localparam int DIM_W  = 13;  // grid size fields
    localparam int IDX_W  = 27;  // flat index width
    localparam int FREQ_W = 14;  // signed frequency counters
    localparam int SVAL_W = 20;  // signed working width of the index math
    localparam int COPY_W = 3;   // copy counters as carried in the queue
    localparam int AREA_W = 2 * DIM_W;

    // request kinds
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_RESTART = 2'd1;
    localparam logic [1:0] REQ_NEXT    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_NUM_LAYERS = 3'd0;
    localparam logic [2:0] CFG_SHIFT_MODE = 3'd1;
    localparam logic [2:0] CFG_HALF_MODE  = 3'd2;
    localparam logic [2:0] CFG_SUBAP_COLS = 3'd3;
    localparam logic [2:0] CFG_SUBAP_ROWS = 3'd4;

    typedef struct packed {
        logic [3:0]       num_layers;
        logic             shift_mode;
        logic             half_mode;
        logic [DIM_W-1:0] subap_cols;
        logic [DIM_W-1:0] subap_rows;
    } t_cfg;

    // one position of the walk, handed from the counter front to the index back end
    typedef struct packed {
        logic              exhausted;
        logic              last;
        logic [IDX_W-1:0]  base;
        logic [DIM_W-1:0]  cols;
        logic [DIM_W-1:0]  rows;
        logic [FREQ_W-1:0] freq_row;
        logic [FREQ_W-1:0] freq_col;
        logic [COPY_W-1:0] row_copy;
        logic [COPY_W-1:0] col_copy;
    } t_pos;

endpackage

// ----- rtl/core/fgpg_front.sv -----
// Request front end: layer table, loop counters and end-of-sequence detection.
`timescale 1ns / 1ps

module fgpg_front
    import fgpg_pkg::*;
#(
    parameter int MAX_LAYERS     = 8,
    parameter int MAX_OVERSAMPLE = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_req,
    input  logic [2:0]       i_layer_index,
    input  logic [DIM_W-1:0] i_layer_cols,
    input  logic [DIM_W-1:0] i_layer_rows,
    input  logic [2:0]       i_layer_oversample,
    input  t_cfg             i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output t_pos             o_pos
);

    localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int OW = $clog2(MAX_OVERSAMPLE + 1);
    localparam int CW = (MAX_OVERSAMPLE > 1) ? $clog2(MAX_OVERSAMPLE) : 1;

    // layer table, no reset
    logic [DIM_W-1:0]  r_tbl_cols [MAX_LAYERS];
    logic [DIM_W-1:0]  r_tbl_rows [MAX_LAYERS];
    logic [OW-1:0]     r_tbl_os   [MAX_LAYERS];
    logic [AREA_W-1:0] r_tbl_area [MAX_LAYERS];

    logic              r_pass, n_pass;
    logic [FREQ_W-1:0] r_row, n_row;
    logic [FREQ_W-1:0] r_col, n_col;
    logic [LW-1:0]     r_lc, n_lc;
    logic [CW-1:0]     r_rc, n_rc;
    logic [CW-1:0]     r_cc, n_cc;
    logic [IDX_W-1:0]  r_base, n_base;
    logic              r_finished, n_finished;

    logic              w_accept, w_load, w_last;
    logic [LW-1:0]     w_slot;
    logic [OW-1:0]     w_os_sat, w_os;
    logic [OW:0]       w_cc_inc, w_rc_inc;
    logic [4:0]        w_used, w_lc_inc;
    logic signed [FREQ_W-1:0] w_half_r, w_half_c, w_col_start, w_col_end;

    assign o_ready  = ~i_full;
    assign w_accept = i_valid & o_ready;
    assign w_slot   = LW'(i_layer_index);
    assign w_load   = w_accept && (i_req == REQ_LOAD)
                      && ({29'd0, i_layer_index} < 32'(MAX_LAYERS));

    always_comb begin
        if (i_layer_oversample == 3'd0) begin
            w_os_sat = OW'(1);
        end else if ({1'b0, i_layer_oversample} > 4'(MAX_OVERSAMPLE)) begin
            w_os_sat = OW'(MAX_OVERSAMPLE);
        end else begin
            w_os_sat = OW'(i_layer_oversample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tbl_cols[w_slot] <= i_layer_cols;
            r_tbl_rows[w_slot] <= i_layer_rows;
            r_tbl_os[w_slot]   <= w_os_sat;
            r_tbl_area[w_slot] <= i_layer_cols * i_layer_rows;
        end
    end

    assign w_os     = r_tbl_os[r_lc];
    assign w_cc_inc = (OW + 1)'(r_cc) + 1'b1;
    assign w_rc_inc = (OW + 1)'(r_rc) + 1'b1;
    assign w_lc_inc = 5'(r_lc) + 1'b1;

    always_comb begin
        if (i_cfg.num_layers == 4'd0) begin
            w_used = 5'd1;
        end else if ({1'b0, i_cfg.num_layers} > 5'(MAX_LAYERS)) begin
            w_used = 5'(MAX_LAYERS);
        end else begin
            w_used = {1'b0, i_cfg.num_layers};
        end
    end

    assign w_half_r    = $signed({2'b00, i_cfg.subap_rows[DIM_W-1:1]});
    assign w_half_c    = $signed({2'b00, i_cfg.subap_cols[DIM_W-1:1]});
    assign w_col_start = r_pass ? 14'sd1 : -w_half_c;
    assign w_col_end   = r_pass ? w_half_c : 14'sd1;

    always_comb begin
        n_pass     = r_pass;
        n_row      = r_row;
        n_col      = r_col;
        n_lc       = r_lc;
        n_rc       = r_rc;
        n_cc       = r_cc;
        n_base     = r_base;
        n_finished = r_finished;
        w_last     = 1'b0;
        if (w_accept) begin
            case (i_req)
                REQ_RESTART: begin
                    n_pass     = 1'b0;
                    n_row      = -w_half_r;
                    n_col      = -w_half_c;
                    n_lc       = '0;
                    n_rc       = '0;
                    n_cc       = '0;
                    n_base     = '0;
                    n_finished = (w_half_r == 14'sd0);
                end
                REQ_NEXT: begin
                    if (!r_finished) begin
                        if (w_cc_inc < {1'b0, w_os}) begin
                            n_cc = r_cc + 1'b1;
                        end else begin
                            n_cc = '0;
                            if (w_rc_inc < {1'b0, w_os}) begin
                                n_rc = r_rc + 1'b1;
                            end else begin
                                n_rc = '0;
                                if (w_lc_inc < w_used) begin
                                    n_base = r_base + IDX_W'(r_tbl_area[r_lc]);
                                    n_lc   = r_lc + 1'b1;
                                end else begin
                                    n_lc   = '0;
                                    n_base = '0;
                                    if ($signed(r_col) + 14'sd1 < w_col_end) begin
                                        n_col = r_col + 1'b1;
                                    end else begin
                                        n_col = w_col_start;
                                        if ($signed(r_row) + 14'sd1 < w_half_r) begin
                                            n_row = r_row + 1'b1;
                                        end else if (!r_pass && !i_cfg.half_mode
                                                     && (14'sd1 < w_half_c)
                                                     && (w_half_r != 14'sd0)) begin
                                            // second pass: positive x frequencies
                                            n_pass = 1'b1;
                                            n_row  = -w_half_r;
                                            n_col  = 14'sd1;
                                        end else begin
                                            n_finished = 1'b1;
                                            w_last     = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass     <= 1'b0;
            r_row      <= -14'sd32;
            r_col      <= -14'sd32;
            r_lc       <= '0;
            r_rc       <= '0;
            r_cc       <= '0;
            r_base     <= '0;
            r_finished <= 1'b0;
        end else begin
            r_pass     <= n_pass;
            r_row      <= n_row;
            r_col      <= n_col;
            r_lc       <= n_lc;
            r_rc       <= n_rc;
            r_cc       <= n_cc;
            r_base     <= n_base;
            r_finished <= n_finished;
        end
    end

    assign o_push = w_accept && (i_req == REQ_NEXT);

    always_comb begin
        o_pos.exhausted = r_finished;
        o_pos.last      = w_last;
        o_pos.base      = r_base;
        o_pos.cols      = r_tbl_cols[r_lc];
        o_pos.rows      = r_tbl_rows[r_lc];
        o_pos.freq_row  = r_row;
        o_pos.freq_col  = r_col;
        o_pos.row_copy  = COPY_W'(r_rc);
        o_pos.col_copy  = COPY_W'(r_cc);
    end

endmodule

// ----- rtl/core/fgpg_queue.sv -----
// Short position queue between the counter front end and the index back end.
`timescale 1ns / 1ps

module fgpg_queue
    import fgpg_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pos i_data,
    input  logic i_pop,
    output t_pos o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_pos          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [NW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + NW'(w_push) - NW'(w_pop);
        end
    end

endmodule

// ----- rtl/core/fgpg_back.sv -----
// Index back end: four-stage pipeline from a walk position to the flat index.
`timescale 1ns / 1ps

module fgpg_back
    import fgpg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_pos             i_pos,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [IDX_W-1:0] o_flat_index,
    output logic             o_conjugate,
    output logic             o_last,
    output logic             o_exhausted
);

    typedef logic signed [SVAL_W-1:0] t_sval;

    typedef struct packed {
        logic             exhausted;
        logic             last;
        logic [IDX_W-1:0] base;
        logic [DIM_W-1:0] cols;
        logic [DIM_W-1:0] rows;
    } t_tag;

    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4;

    // stage 1: copy offsets and centering
    t_tag                  r_s1_tag;
    t_sval                 r_s1_jy, r_s1_jx;
    logic [DIM_W+COPY_W-1:0] w_ry, w_rx;
    t_sval                 w_jy0, w_jx0, w_jyc, w_jxc, w_jy, w_jx;
    t_sval                 w_rows, w_cols, w_hrows, w_hcols;

    // stage 2: hermitian mirror
    t_tag  r_s2_tag;
    t_sval r_s2_jx, r_s2_row;
    t_sval w2_rows, w2_cols, w2_hcols, w2_jx, w2_row;
    logic  w2_conj;
    logic  r_s2_conj;

    // stage 3: row times columns
    logic signed [SVAL_W+DIM_W:0] w3_prod;
    logic [IDX_W-1:0] r_s3_prod, r_s3_sum;
    logic             r_s3_conj, r_s3_last, r_s3_exh;

    assign w_en  = ~r_v4 | i_ready;
    assign o_pop = w_en & ~i_empty;

    assign w_ry    = i_cfg.subap_rows * i_pos.row_copy;
    assign w_rx    = i_cfg.subap_cols * i_pos.col_copy;
    assign w_jy0   = $signed({{(SVAL_W-FREQ_W){i_pos.freq_row[FREQ_W-1]}}, i_pos.freq_row})
                     + $signed({4'd0, w_ry});
    assign w_jx0   = $signed({{(SVAL_W-FREQ_W){i_pos.freq_col[FREQ_W-1]}}, i_pos.freq_col})
                     + $signed({4'd0, w_rx});
    assign w_rows  = $signed({7'd0, i_pos.rows});
    assign w_cols  = $signed({7'd0, i_pos.cols});
    assign w_hrows = $signed({8'd0, i_pos.rows[DIM_W-1:1]});
    assign w_hcols = $signed({8'd0, i_pos.cols[DIM_W-1:1]});
    assign w_jyc   = w_jy0 + w_hrows;
    assign w_jxc   = w_jx0 + w_hcols;

    always_comb begin
        if (i_cfg.shift_mode) begin
            // negative frequencies wrap to the top of the grid
            w_jy = (w_jy0 < 0) ? w_jy0 + w_rows : w_jy0;
            w_jx = (w_jx0 < 0) ? w_jx0 + w_cols : w_jx0;
        end else begin
            w_jy = (w_jyc >= w_rows) ? w_jyc - w_rows : w_jyc;
            w_jx = (w_jxc >= w_cols) ? w_jxc - w_cols : w_jxc;
        end
    end

    assign w2_rows  = $signed({7'd0, r_s1_tag.rows});
    assign w2_cols  = $signed({7'd0, r_s1_tag.cols});
    assign w2_hcols = $signed({8'd0, r_s1_tag.cols[DIM_W-1:1]});
    assign w2_conj  = i_cfg.shift_mode & i_cfg.half_mode & (r_s1_jx > w2_hcols);
    assign w2_jx    = w2_conj ? w2_cols - r_s1_jx : r_s1_jx;

    always_comb begin
        if (!w2_conj) begin
            w2_row = r_s1_jy;
        end else if (r_s1_jy == 0) begin
            w2_row = '0;
        end else begin
            w2_row = w2_rows - r_s1_jy;
        end
    end

    assign w3_prod = r_s2_row * $signed({1'b0, r_s2_tag.cols});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_tag <= '{exhausted: i_pos.exhausted, last: i_pos.last, base: i_pos.base,
                          cols: i_pos.cols, rows: i_pos.rows};
            r_s1_jy  <= w_jy;
            r_s1_jx  <= w_jx;

            r_s2_tag  <= r_s1_tag;
            r_s2_jx   <= w2_jx;
            r_s2_row  <= w2_row;
            r_s2_conj <= w2_conj;

            r_s3_prod <= w3_prod[IDX_W-1:0];
            r_s3_sum  <= r_s2_tag.base + {{(IDX_W-SVAL_W){r_s2_jx[SVAL_W-1]}}, r_s2_jx};
            r_s3_conj <= r_s2_conj;
            r_s3_last <= r_s2_tag.last;
            r_s3_exh  <= r_s2_tag.exhausted;

            // an exhausted request reports zeros in every other field
            o_flat_index <= r_s3_exh ? '0 : r_s3_prod + r_s3_sum;
            o_conjugate  <= r_s3_conj & ~r_s3_exh;
            o_last       <= r_s3_last & ~r_s3_exh;
            o_exhausted  <= r_s3_exh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= ~i_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;

endmodule

// ----- rtl/core/frequency_group_permutation_gen.sv -----
// Top level of the frequency-group permutation address generator.
`timescale 1ns / 1ps

// Emits the flat indices that gather equal spatial-frequency points of up to
// MAX_LAYERS stacked 2-D Fourier grids into contiguous blocks, one index per
// "next" request. Requests arrive on the slave stream with the request kind in
// tuser: load writes one layer descriptor (columns, rows, oversampling) into
// the layer table, restart rewinds the walk, next emits one result on the
// master stream. Results carry the flat index in tdata, conjugate and
// exhausted flags in tuser, and tlast on the final index of the sequence; a
// next request after the end returns exhausted with all other fields zero.
// Loads and restarts produce no result. The request side takes one request
// per clock while the position queue has room, so sustained rate is one index
// per cycle when the master side does not stall; a result passes through the
// queue and then the four pipeline stages before it is valid on the master
// side. A four-entry position queue sits between the counter front end and
// the four-stage index pipeline, so the request side keeps going while results
// wait on the master side. Configuration writes are taken at any time but
// must only be issued while no results are outstanding. A layer must be
// loaded before a sequence uses it.

module frequency_group_permutation_gen
    import fgpg_pkg::*;
#(
    parameter int MAX_LAYERS     = 8,
    parameter int MAX_OVERSAMPLE = 4,
    parameter int QUEUE_DEPTH    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // layer_index[2:0], layer_cols[15:3],
                                     // layer_rows[28:16], layer_oversample[31:29]
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // flat_index[26:0], zero fill above
    output logic [1:0]  o_m_tuser,   // conjugate[0], exhausted[1]
    output logic        o_m_tlast,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    t_cfg             r_cfg;
    t_pos             w_push_pos, w_head_pos;
    logic             w_push, w_pop, w_full, w_empty;
    logic [IDX_W-1:0] w_flat;
    logic             w_conj, w_exh;

    // config registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_layers <= 4'd1;
            r_cfg.shift_mode <= 1'b0;
            r_cfg.half_mode  <= 1'b0;
            r_cfg.subap_cols <= 13'd64;
            r_cfg.subap_rows <= 13'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_LAYERS: r_cfg.num_layers <= i_cfg_data[3:0];
                CFG_SHIFT_MODE: r_cfg.shift_mode <= i_cfg_data[0];
                CFG_HALF_MODE:  r_cfg.half_mode  <= i_cfg_data[0];
                CFG_SUBAP_COLS: r_cfg.subap_cols <= i_cfg_data;
                CFG_SUBAP_ROWS: r_cfg.subap_rows <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front end: table, walk counters, last detection
    fgpg_front #(
        .MAX_LAYERS     (MAX_LAYERS),
        .MAX_OVERSAMPLE (MAX_OVERSAMPLE)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_s_tvalid),
        .o_ready            (o_s_tready),
        .i_req              (i_s_tuser),
        .i_layer_index      (i_s_tdata[2:0]),
        .i_layer_cols       (i_s_tdata[15:3]),
        .i_layer_rows       (i_s_tdata[28:16]),
        .i_layer_oversample (i_s_tdata[31:29]),
        .i_cfg              (r_cfg),
        .i_full             (w_full),
        .o_push             (w_push),
        .o_pos              (w_push_pos)
    );

    // positions waiting for the index pipeline
    fgpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_pos),
        .i_pop   (w_pop),
        .o_data  (w_head_pos),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // back end: index arithmetic, output register
    fgpg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_pos        (w_head_pos),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_flat_index (w_flat),
        .o_conjugate  (w_conj),
        .o_last       (o_m_tlast),
        .o_exhausted  (w_exh)
    );

    assign o_m_tdata = {5'd0, w_flat};
    assign o_m_tuser = {w_exh, w_conj};

endmodule
